// ===== rtl/core/c8wd_pkg.sv =====
// Shared types, constants and the CRC-8 byte update for the word deframer.
// No dependencies; used by c8wd_word_fsm, crc8_checked_word_deframer, c8wd_checker and the testbench.

package c8wd_pkg;

  localparam int unsigned CfgW     = 5;   // words_per_frame register width
  localparam int unsigned IdxW     = 4;   // word_index field width
  localparam int unsigned ValW     = 16;  // word_value field width
  localparam logic [CfgW-1:0] MaxWords = 5'd16;
  localparam logic [CfgW-1:0] CfgReset = 5'd3;

  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcInit = 8'hFF;
  localparam logic [7:0] CrcTop  = 8'h80;

  localparam logic StatusOk     = 1'b0;
  localparam logic StatusCrcErr = 1'b1;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic [IdxW-1:0] index;
    logic            status;
    logic            last;
  } result_t;

  // One message byte through CRC-8 (poly 0x31, MSB first), unrolled.
  function automatic logic [7:0] crc8_feed(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((c & CrcTop) != 8'h00) begin
        c = (c << 1) ^ CrcPoly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/c8wd_word_fsm.sv =====
// Byte-phase sequencer of the deframer: word assembly, CRC check, frame count.
// Depends on c8wd_pkg.

module c8wd_word_fsm (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,      // consume the staged byte
  input  logic [7:0]                 byte_i,
  input  logic                       start_i,
  input  logic [c8wd_pkg::CfgW-1:0]  words_cfg_i,
  output logic                       res_valid_o, // staged byte yields a result
  output c8wd_pkg::result_t          res_o
);

  typedef enum logic [2:0] {
    PhHigh  = 3'b001,
    PhLow   = 3'b010,
    PhCheck = 3'b100
  } phase_e;

  phase_e                    phase_q, phase_d, phase_eff;
  logic [7:0]                high_q, high_d;
  logic [7:0]                low_q, low_d;
  logic [7:0]                crc_q, crc_d, crc_eff, crc_next;
  logic [c8wd_pkg::CfgW-1:0] done_q, done_d, done_eff, done_inc, n_words;
  logic                      abort_q, abort_d, abort_eff;
  logic                      crc_ok;

  // Clamp word count: zero acts as one, above the maximum acts as the maximum.
  always_comb begin
    if (words_cfg_i == '0) begin
      n_words = c8wd_pkg::CfgW'(1);
    end else if (words_cfg_i > c8wd_pkg::MaxWords) begin
      n_words = c8wd_pkg::MaxWords;
    end else begin
      n_words = words_cfg_i;
    end
  end

  // Frame start resets the word state before the byte is handled.
  assign phase_eff = start_i ? PhHigh : phase_q;
  assign crc_eff   = start_i ? c8wd_pkg::CrcInit : crc_q;
  assign done_eff  = start_i ? '0 : done_q;
  assign abort_eff = start_i ? 1'b0 : abort_q;

  assign crc_next = c8wd_pkg::crc8_feed(crc_eff, byte_i);
  assign crc_ok   = (byte_i == crc_eff);
  assign done_inc = done_eff + c8wd_pkg::CfgW'(1);

  always_comb begin
    phase_d     = phase_eff;
    high_d      = high_q;
    low_d       = low_q;
    crc_d       = crc_eff;
    done_d      = done_eff;
    abort_d     = abort_eff;
    res_valid_o = 1'b0;
    res_o.value  = '0;
    res_o.index  = done_eff[c8wd_pkg::IdxW-1:0];
    res_o.status = c8wd_pkg::StatusOk;
    res_o.last   = 1'b0;
    if (!abort_eff) begin
      case (phase_eff)
        PhHigh: begin
          high_d  = byte_i;
          crc_d   = crc_next;
          phase_d = PhLow;
        end
        PhLow: begin
          low_d   = byte_i;
          crc_d   = crc_next;
          phase_d = PhCheck;
        end
        default: begin
          res_valid_o = 1'b1;
          phase_d     = PhHigh;
          crc_d       = c8wd_pkg::CrcInit;
          if (crc_ok) begin
            res_o.value = {high_q, low_q};
            done_d      = done_inc;
            if (done_inc >= n_words) begin
              res_o.last = 1'b1;
              abort_d    = 1'b1;
            end
          end else begin
            res_o.status = c8wd_pkg::StatusCrcErr;
            res_o.last   = 1'b1;
            abort_d      = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHigh;
      high_q  <= '0;
      low_q   <= '0;
      crc_q   <= c8wd_pkg::CrcInit;
      done_q  <= '0;
      abort_q <= 1'b1;
    end else if (step_i) begin
      phase_q <= phase_d;
      high_q  <= high_d;
      low_q   <= low_d;
      crc_q   <= crc_d;
      done_q  <= done_d;
      abort_q <= abort_d;
    end
  end

endmodule

// ===== rtl/core/crc8_checked_word_deframer.sv =====
// Top level of the CRC-8 checked word deframer: input stage, sequencer, result register.
// Depends on c8wd_pkg and c8wd_word_fsm.

// Takes response bytes one request at a time on the slave stream, with tuser
// marking the first byte of a frame, and groups them as MSB, LSB, CRC-8 check
// byte (poly 0x31, init 0xFF per word, no reflection, no final xor). Each good
// word comes out as a request with its 16-bit value and frame index; the
// frame's last word carries tlast. The first bad check byte gives an error
// request (tuser high, value zero, tlast high) and the rest of the frame is
// dropped until the next frame start. Bytes outside a frame are dropped.
// Out of reset the block waits for a frame start. Throughput is one byte per
// clock, unless a check byte must wait for a held result to be taken; a
// result passes through the input register and then the result register,
// with the byte-wide CRC update as a single unrolled step in between.
// words_per_frame (cfg_wdata_i) resets to 3; 0 acts as 1 and values above
// 16 act as 16. Write it only while no frame is in flight.

module crc8_checked_word_deframer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_we_i,
  input  logic [c8wd_pkg::CfgW-1:0] cfg_wdata_i,  // words_per_frame
  // byte stream in
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,  // [7:0] rx_byte
  input  logic                      s_axis_tuser,  // [0] frame_start
  // word stream out
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [23:0]               m_axis_tdata,  // [15:0] word_value, [19:16] word_index, rest 0
  output logic                      m_axis_tuser,  // [0] status
  output logic                      m_axis_tlast   // last_of_frame
);

  logic [c8wd_pkg::CfgW-1:0] words_cfg_q;

  // input stage
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_start_q;

  // result register
  logic              out_valid_q;
  c8wd_pkg::result_t out_q;

  logic              res_valid;
  c8wd_pkg::result_t res;
  logic              step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_cfg_q <= c8wd_pkg::CfgReset;
    end else if (cfg_we_i) begin
      words_cfg_q <= cfg_wdata_i;
    end
  end

  // Staged byte moves on unless it makes a result and the result slot is held.
  assign step          = in_valid_q && (!res_valid || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser;
    end
  end

  c8wd_word_fsm u_word_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .start_i     (in_start_q),
    .words_cfg_i (words_cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_q.index, out_q.value};
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tlast  = out_q.last;

endmodule

// ===== rtl/core/c8wd_checker.sv =====
// Port-level checks for crc8_checked_word_deframer, bound to the top level.
// Depends on c8wd_pkg and the top level's port list.

module c8wd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // A pending result is not withdrawn.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result request dropped while stalled");

  // A CRC error always closes the frame.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == c8wd_pkg::StatusCrcErr) |-> m_axis_tlast)
    else $error("error result without last flag");

  // Error results carry a zero word.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == c8wd_pkg::StatusCrcErr)
      |-> (m_axis_tdata[15:0] == 16'h0000))
    else $error("error result with nonzero word");

  // m_axis_tvalid is low in the cycle that follows any cycle in reset.
  a_no_early: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result right after reset");

  // Padding bits stay zero.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[23:20] == 4'h0))
    else $error("tdata padding not zero");

endmodule

bind crc8_checked_word_deframer c8wd_checker u_c8wd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== verif/tb_crc8_checked_word_deframer.sv =====
// Testbench for crc8_checked_word_deframer: byte stream in, checked words out.
// Predicts each word from its own CRC-8 model and compares every field in order.
// Depends on c8wd_pkg and the RTL of crc8_checked_word_deframer.
`timescale 1ns / 1ps

module tb_crc8_checked_word_deframer;

  localparam int unsigned PhaseBytes   = 150;
  localparam int unsigned DrainLimit   = 2000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned CycleLimit   = 1000000;
  localparam int unsigned MaxPrinted   = 40;

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      cfg_we_i      = 1'b0;
  logic [c8wd_pkg::CfgW-1:0] cfg_wdata_i   = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [7:0]                s_axis_tdata  = 8'h00;
  logic                      s_axis_tuser  = 1'b0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [23:0]               m_axis_tdata;
  logic                      m_axis_tuser;
  logic                      m_axis_tlast;

  crc8_checked_word_deframer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // deframer state as the testbench sees it
  logic [c8wd_pkg::CfgW-1:0] words_cfg   = c8wd_pkg::CfgReset;
  logic [1:0]                phase       = 2'd0;
  logic [7:0]                msb_byte    = 8'h00;
  logic [7:0]                lsb_byte    = 8'h00;
  logic [7:0]                crc_acc     = c8wd_pkg::CrcInit;
  logic [4:0]                words_seen  = 5'd0;
  logic                      frame_idle  = 1'b1;

  c8wd_pkg::result_t expected_words[$];
  int unsigned live_bytes  = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          src_gaps    = 1'b1;
  bit          sink_stalls = 1'b1;

  task automatic report_mismatch(input string what);
    if (error_count < MaxPrinted) begin
      $display("MISMATCH @%0t: %s", $time, what);
    end
    error_count++;
  endtask

  function automatic logic [7:0] crc_after(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = r[7] ^ b[k];
      r  = {r[6:0], 1'b0} ^ (fb ? c8wd_pkg::CrcPoly : 8'h00);
    end
    return r;
  endfunction

  // 0 acts as 1, anything above the maximum is clamped
  function automatic int unsigned eff_words();
    if (words_cfg == 0) return 1;
    if (words_cfg > c8wd_pkg::MaxWords) return 32'(c8wd_pkg::MaxWords);
    return 32'(words_cfg);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Returns 1 when the byte is consumed, 0 when the block drops it.
  function automatic bit predict_byte(input logic [7:0] b, input logic start);
    c8wd_pkg::result_t w;
    if (start) begin
      phase      = 2'd0;
      crc_acc    = c8wd_pkg::CrcInit;
      words_seen = 5'd0;
      frame_idle = 1'b0;
    end
    if (frame_idle) return 1'b0;
    case (phase)
      2'd0: begin
        msb_byte = b;
        crc_acc  = crc_after(crc_acc, b);
        phase    = 2'd1;
      end
      2'd1: begin
        lsb_byte = b;
        crc_acc  = crc_after(crc_acc, b);
        phase    = 2'd2;
      end
      default: begin
        phase   = 2'd0;
        w.index = words_seen[c8wd_pkg::IdxW-1:0];
        if (b == crc_acc) begin
          w.value    = {msb_byte, lsb_byte};
          w.status   = c8wd_pkg::StatusOk;
          words_seen = words_seen + 5'd1;
          w.last     = (words_seen >= eff_words());
          if (w.last) frame_idle = 1'b1;
        end else begin
          w.value    = '0;
          w.status   = c8wd_pkg::StatusCrcErr;
          w.last     = 1'b1;
          frame_idle = 1'b1;
        end
        crc_acc = c8wd_pkg::CrcInit;
        expected_words.push_back(w);
      end
    endcase
    return 1'b1;
  endfunction

  // Called at a rising edge; returns once the byte is taken and any gap is over.
  task automatic send_byte(input logic [7:0] b, input logic start);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= start;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    if (predict_byte(b, start)) live_bytes++;
    gap = src_gaps ? pick_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_word(input logic [7:0] hi, input logic [7:0] lo, input logic start,
                           input bit corrupt);
    logic [7:0] chk;
    logic [7:0] flip;
    chk  = crc_after(crc_after(c8wd_pkg::CrcInit, hi), lo);
    flip = 8'($urandom_range(1, 255));
    if (corrupt) chk = chk ^ flip;
    send_byte(hi, start);
    send_byte(lo, 1'b0);
    send_byte(chk, 1'b0);
  endtask

  // Wait for every outstanding word, then let the pipeline empty.
  task automatic drain();
    int unsigned waited;
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    waited = 0;
    while (expected_words.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_words.size() != 0) begin
      report_mismatch($sformatf("%0d expected words never arrived", expected_words.size()));
      expected_words.delete();
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_word_count(input logic [c8wd_pkg::CfgW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    words_cfg    = v;
  endtask

  // Mostly clean frames; some with a bad check byte, cut short, overlong,
  // or followed by stray bytes.
  task automatic random_frame();
    int unsigned n, kind, full, bad_at, tail;
    n      = eff_words();
    kind   = $urandom_range(0, 99);
    full   = n;
    bad_at = n + 8;
    tail   = 0;
    if (kind < 15) begin
      bad_at = $urandom_range(0, n - 1);
    end else if (kind < 27) begin
      full = $urandom_range(0, n - 1);
      tail = $urandom_range(1, 2);
    end else if (kind < 32) begin
      full = n + $urandom_range(1, 2);
    end
    for (int unsigned k = 0; k < full; k++) begin
      send_word(pick_byte(), pick_byte(), k == 0, k == bad_at);
    end
    for (int unsigned k = 0; k < tail; k++) begin
      send_byte(pick_byte(), full == 0 && k == 0);
    end
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(pick_byte(), $urandom_range(0, 7) == 0);
    end
  endtask

  task automatic test_idle_after_reset();
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  task automatic test_good_frame();
    send_word(8'h00, 8'h00, 1'b1, 1'b0);
    send_word(8'hFF, 8'hFF, 1'b0, 1'b0);
    send_word(8'hBE, 8'hEF, 1'b0, 1'b0);
    send_byte(8'h5A, 1'b0);  // frame complete, dropped
  endtask

  task automatic test_crc_abort();
    send_word(8'h12, 8'h34, 1'b1, 1'b0);
    send_word(8'hAB, 8'hCD, 1'b0, 1'b1);
    send_byte(8'hA5, 1'b0);  // aborted, dropped
  endtask

  task automatic test_restart_mid_word();
    send_byte(8'h80, 1'b1);
    send_word(8'h01, 8'h7F, 1'b1, 1'b0);
    send_word(8'hC3, 8'h3C, 1'b0, 1'b1);
  endtask

  task automatic test_word_count(input logic [c8wd_pkg::CfgW-1:0] v, input bit src,
                                 input bit snk);
    int unsigned mark;
    drain();
    write_word_count(v);
    src_gaps    = src;
    sink_stalls = snk;
    mark        = live_bytes;
    while (live_bytes - mark < PhaseBytes) random_frame();
    // leave the block idle for the next register write
    if (!frame_idle) send_word(pick_byte(), pick_byte(), 1'b1, 1'b1);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_after_reset();
    test_good_frame();
    test_crc_abort();
    test_restart_mid_word();
    test_word_count(5'd1, 1'b1, 1'b1);
    test_word_count(5'd0, 1'b1, 1'b0);
    test_word_count(5'd16, 1'b0, 1'b0);
    test_word_count(5'd31, 1'b1, 1'b1);
    test_word_count(5'd17, 1'b0, 1'b1);
    test_word_count(5'($urandom_range(2, 15)), 1'b1, 1'b1);
    test_word_count(5'd3, 1'b1, 1'b1);
    test_word_count(5'($urandom_range(0, 31)), 1'b1, 1'b1);
    drain();
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // result side back-pressure
  initial begin : sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (sink_stalls && $urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
    end
  end

  // Outputs are stable at the falling edge; a request seen here is taken
  // at the next rising edge.
  always @(negedge clk_i) begin : word_check
    c8wd_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word tdata=%h tuser=%b tlast=%b",
                                  m_axis_tdata, m_axis_tuser, m_axis_tlast));
      end else begin
        want = expected_words.pop_front();
        if (m_axis_tdata[15:0] !== want.value)
          report_mismatch($sformatf("value %h, want %h", m_axis_tdata[15:0], want.value));
        if (m_axis_tdata[19:16] !== want.index)
          report_mismatch($sformatf("index %0d, want %0d", m_axis_tdata[19:16], want.index));
        if (m_axis_tdata[23:20] !== 4'h0)
          report_mismatch($sformatf("tdata pad bits %h", m_axis_tdata[23:20]));
        if (m_axis_tuser !== want.status)
          report_mismatch($sformatf("status %b, want %b", m_axis_tuser, want.status));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("last %b, want %b", m_axis_tlast, want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
